// ===== rtl/core/ppis_pkg.sv =====
// ----------------------------------------------------------------------------
// ppis_pkg
// Shared types and constants of the positional PID unit with integral
// separation: register indexes, port widths and the configuration record.
// ----------------------------------------------------------------------------
package ppis_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int INTEGRAL_WIDTH_DEF = 25;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 24;
  localparam int OLIM_W     = 15;
  localparam int THR_W      = 16;
  localparam int DRIVE_W    = 16;
  localparam int FRAC_BITS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_ENABLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_THRESHOLD  = 3'd6;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [ILIM_W-1:0] integral_limit;
    logic [OLIM_W-1:0] output_limit;
    logic              sep_enable;
    logic [THR_W-1:0]  sep_threshold;
  } ppis_cfg_t;

endpackage

// ===== rtl/core/ppis_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppis_cfg_regs
// Configuration register file: one write per cycle, no read-back; writes
// to an index past the register list are dropped.
// ----------------------------------------------------------------------------
module ppis_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ppis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ppis_pkg::ppis_cfg_t             cfg
);
  import ppis_pkg::*;

  ppis_cfg_t cfg_r;
  ppis_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:         cfg_nxt.gain_p         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_nxt.gain_i         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_nxt.gain_d         = cfg_wdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_wdata[ILIM_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_nxt.output_limit   = cfg_wdata[OLIM_W-1:0];
        REG_SEP_ENABLE:     cfg_nxt.sep_enable     = cfg_wdata[0];
        REG_SEP_THRESHOLD:  cfg_nxt.sep_threshold  = cfg_wdata[THR_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/ppis_integrator.sv =====
// ----------------------------------------------------------------------------
// ppis_integrator
// Error, derivative difference and the next integral value: separation
// test, accumulate and symmetric clamp against the saturated limit.
// ----------------------------------------------------------------------------
module ppis_integrator #(
  parameter int SAMPLE_WIDTH   = ppis_pkg::SAMPLE_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = ppis_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0]   setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0]   measured,
  input  logic signed [INTEGRAL_WIDTH-1:0] integral,
  input  logic signed [SAMPLE_WIDTH:0]     prev_error,
  input  ppis_pkg::ppis_cfg_t              cfg,
  output logic signed [SAMPLE_WIDTH:0]     error,
  output logic signed [SAMPLE_WIDTH+1:0]   error_diff,
  output logic signed [INTEGRAL_WIDTH-1:0] integral_nxt
);
  import ppis_pkg::*;

  localparam int EW  = SAMPLE_WIDTH + 1;
  localparam int CW  = (EW > THR_W) ? EW : THR_W;
  localparam int AW0 = ((INTEGRAL_WIDTH > EW) ? INTEGRAL_WIDTH : EW) + 1;
  localparam int AW  = (AW0 > ILIM_W + 1) ? AW0 : ILIM_W + 1;
  localparam logic signed [AW-1:0] IMAX = AW'((65'sd1 <<< (INTEGRAL_WIDTH - 1)) - 65'sd1);

  logic signed [EW-1:0] sp_x;
  logic signed [EW-1:0] ms_x;
  logic        [EW-1:0] mag;
  logic                 sep_clear;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] lim_x;
  logic signed [AW-1:0] ilim;
  logic signed [AW-1:0] acc_clamped;

  assign sp_x  = EW'(setpoint);
  assign ms_x  = EW'(measured);
  assign error = sp_x - ms_x;
  assign mag   = error[EW-1] ? EW'(-error) : EW'(error);

  assign sep_clear = cfg.sep_enable && (CW'(mag) >= CW'(cfg.sep_threshold));

  assign acc   = AW'(integral) + AW'(error);
  assign lim_x = AW'($signed({1'b0, cfg.integral_limit}));
  // limit saturates at the largest value the integral can hold
  assign ilim  = (lim_x > IMAX) ? IMAX : lim_x;

  always_comb begin
    priority if (sep_clear) begin
      acc_clamped = '0;
    end else if (acc > ilim) begin
      acc_clamped = ilim;
    end else if (acc < -ilim) begin
      acc_clamped = -ilim;
    end else begin
      acc_clamped = acc;
    end
  end

  assign integral_nxt = INTEGRAL_WIDTH'(acc_clamped);
  assign error_diff   = (EW+1)'(error) - (EW+1)'(prev_error);

endmodule

// ===== rtl/core/positional_pid_integral_separation_unit.sv =====
// ----------------------------------------------------------------------------
// positional_pid_integral_separation_unit
// Positional PID controller with optional integral separation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request of setpoint and
//   measured sample; the result channel (out_valid/out_ready) returns the
//   clamped drive and a flag that the output clamp acted, one per request,
//   in order.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while no
//   request is in flight; each write takes effect at the next edge.
//   From acceptance to out_valid, the accepting edge loads the input register,
//   then the error and integral update, the three gain multiplies, and sum
//   and clamp into the output register are each registered in turn.
//   Throughput is one request per cycle while out_ready is high; the single
//   pass that updates the integral and previous error sets it.
//   When out_ready is low the pipeline fills behind the held result and
//   in_ready drops once all four stages are occupied; bubbles are squeezed
//   out so up to four requests stay accepted during a stall.
//   Synchronous reset clears the configuration registers, the integral and
//   the previous error, and empties the pipeline; stage data is not reset.
// ----------------------------------------------------------------------------
module positional_pid_integral_separation_unit #(
  parameter int SAMPLE_WIDTH   = ppis_pkg::SAMPLE_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = ppis_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ppis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppis_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_measured,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ppis_pkg::DRIVE_W-1:0]  out_drive,
  output logic                                out_drive_clamped
);
  import ppis_pkg::*;

  localparam int EW   = SAMPLE_WIDTH + 1;
  localparam int DW   = SAMPLE_WIDTH + 2;
  localparam int PPW  = EW + GAIN_W;
  localparam int PIW  = INTEGRAL_WIDTH + GAIN_W;
  localparam int PDW  = DW + GAIN_W;
  localparam int SPW  = PPW - FRAC_BITS;
  localparam int SIW  = PIW - FRAC_BITS;
  localparam int SDW  = PDW - FRAC_BITS;
  localparam int SMW0 = (SIW > SDW) ? SIW : SDW;
  localparam int SMW  = SMW0 + 2;

  ppis_cfg_t cfg;

  // pipeline control
  logic v0_r, v1_r, v2_r, v3_r;
  logic v0_nxt, v1_nxt, v2_nxt, v3_nxt;
  logic take0, take1, take2, take3;
  logic rdy0, rdy1, rdy2, rdy3;
  logic load0;

  // state
  logic signed [INTEGRAL_WIDTH-1:0] integral_r;
  logic signed [EW-1:0]             prev_err_r;

  // stage payloads
  logic signed [SAMPLE_WIDTH-1:0]   sp0_r, ms0_r;
  logic signed [EW-1:0]             err1_r, err_c;
  logic signed [DW-1:0]             derr1_r, derr_c;
  logic signed [INTEGRAL_WIDTH-1:0] integ1_r, integ_c;
  logic signed [SPW-1:0]            pp2_r;
  logic signed [SIW-1:0]            pi2_r;
  logic signed [SDW-1:0]            pd2_r;
  logic signed [DRIVE_W-1:0]        drive3_r, drive_c;
  logic                             clamped3_r, clamped_c;

  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic signed [PPW-1:0]    prod_p;
  logic signed [PIW-1:0]    prod_i;
  logic signed [PDW-1:0]    prod_d;
  logic signed [SMW-1:0]    sum;
  logic signed [SMW-1:0]    olim;

  ppis_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ppis_integrator #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_integ (
    .setpoint     (sp0_r),
    .measured     (ms0_r),
    .integral     (integral_r),
    .prev_error   (prev_err_r),
    .cfg          (cfg),
    .error        (err_c),
    .error_diff   (derr_c),
    .integral_nxt (integ_c)
  );

  assign take3 = v3_r && out_ready;
  assign rdy3  = !v3_r || take3;
  assign take2 = v2_r && rdy3;
  assign rdy2  = !v2_r || take2;
  assign take1 = v1_r && rdy2;
  assign rdy1  = !v1_r || take1;
  assign take0 = v0_r && rdy1;
  assign rdy0  = !v0_r || take0;
  assign load0 = in_valid && rdy0;

  assign v0_nxt = load0 || (v0_r && !take0);
  assign v1_nxt = take0 || (v1_r && !take1);
  assign v2_nxt = take1 || (v2_r && !take2);
  assign v3_nxt = take2 || (v3_r && !take3);

  assign kp = $signed(cfg.gain_p);
  assign ki = $signed(cfg.gain_i);
  assign kd = $signed(cfg.gain_d);

  assign prod_p = kp * err1_r;
  assign prod_i = ki * integ1_r;
  assign prod_d = kd * derr1_r;

  // arithmetic shift floors each scaled product
  assign sum  = SMW'(pp2_r) + SMW'(pi2_r) + SMW'(pd2_r);
  assign olim = SMW'($signed({1'b0, cfg.output_limit}));

  always_comb begin
    priority if (sum > olim) begin
      drive_c   = DRIVE_W'(olim);
      clamped_c = 1'b1;
    end else if (sum < -olim) begin
      drive_c   = DRIVE_W'(-olim);
      clamped_c = 1'b1;
    end else begin
      drive_c   = DRIVE_W'(sum);
      clamped_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      integral_r <= '0;
      prev_err_r <= '0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      // advance the loop state as the request leaves the input register
      if (take0) begin
        integral_r <= integ_c;
        prev_err_r <= err_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      sp0_r <= in_setpoint;
      ms0_r <= in_measured;
    end
    if (take0) begin
      err1_r   <= err_c;
      derr1_r  <= derr_c;
      integ1_r <= integ_c;
    end
    if (take1) begin
      pp2_r <= SPW'(prod_p >>> FRAC_BITS);
      pi2_r <= SIW'(prod_i >>> FRAC_BITS);
      pd2_r <= SDW'(prod_d >>> FRAC_BITS);
    end
    if (take2) begin
      drive3_r   <= drive_c;
      clamped3_r <= clamped_c;
    end
  end

  assign in_ready          = rdy0;
  assign out_valid         = v3_r;
  assign out_drive         = drive3_r;
  assign out_drive_clamped = clamped3_r;

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_full_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && out_valid && !out_ready)
    else $error("input stalled with a free stage");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !take0 |=> $stable(integral_r) && $stable(prev_err_r))
    else $error("loop state moved without a request");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v2_r))
    else $error("result appeared without a request in the multiply stage");

endmodule

// ===== verif/ppis_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppis_drive_checker
// Watches the configuration port and both handshake channels of the positional
// PID unit, keeps its own copy of the registers, the error integral and the
// previous error, predicts drive and clamp flag for every accepted request
// and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module ppis_drive_checker
  import ppis_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] in_setpoint,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] in_measured,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [DRIVE_W-1:0]          out_drive,
  input  logic                               out_drive_clamped,
  output int                                 drive_outstanding,
  output int                                 mismatch_count
);

  localparam longint INTEG_MAX = (longint'(1) << (INTEGRAL_WIDTH_DEF - 1)) - 1;
  localparam int     PRINT_CAP = 40;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } drive_result_t;

  // register mirror
  logic signed [GAIN_W-1:0] gain_p_q;
  logic signed [GAIN_W-1:0] gain_i_q;
  logic signed [GAIN_W-1:0] gain_d_q;
  logic [ILIM_W-1:0]        integ_limit_q;
  logic [OLIM_W-1:0]        drive_limit_q;
  logic                     sep_enable_q;
  logic [THR_W-1:0]         sep_threshold_q;

  // controller state
  logic signed [INTEGRAL_WIDTH_DEF-1:0] integ_acc;
  logic signed [SAMPLE_WIDTH_DEF:0]     last_err;

  drive_result_t drive_expect_q[$];
  int            fail_total = 0;

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the integral and previous error by one sample and form the result.
  function automatic drive_result_t pid_drive_predict(
    input logic signed [SAMPLE_WIDTH_DEF-1:0] sp,
    input logic signed [SAMPLE_WIDTH_DEF-1:0] ms
  );
    logic signed [SAMPLE_WIDTH_DEF:0] err;
    longint e, mag, acc, ilim, d, sum, drv;
    drive_result_t r;
    err  = sp - ms;
    e    = longint'(err);
    mag  = (e < 0) ? -e : e;
    ilim = longint'(integ_limit_q);
    if (ilim > INTEG_MAX) ilim = INTEG_MAX;
    if (sep_enable_q && mag >= longint'(sep_threshold_q)) acc = 0;
    else acc = longint'(integ_acc) + e;
    acc       = clamp_sym(acc, ilim);
    integ_acc = acc[INTEGRAL_WIDTH_DEF-1:0];
    d         = e - longint'(last_err);
    last_err  = err;
    // shift each product on its own: floor, not truncation
    sum = ((longint'(gain_p_q) * e) >>> FRAC_BITS)
        + ((longint'(gain_i_q) * acc) >>> FRAC_BITS)
        + ((longint'(gain_d_q) * d) >>> FRAC_BITS);
    drv       = clamp_sym(sum, longint'(drive_limit_q));
    r.drive   = drv[DRIVE_W-1:0];
    r.clamped = (drv != sum);
    return r;
  endfunction

  always @(posedge clk) begin
    drive_result_t exp_r;
    if (!rst_n) begin
      gain_p_q        = '0;
      gain_i_q        = '0;
      gain_d_q        = '0;
      integ_limit_q   = '0;
      drive_limit_q   = '0;
      sep_enable_q    = 1'b0;
      sep_threshold_q = '0;
      integ_acc       = '0;
      last_err        = '0;
      drive_expect_q.delete();
      drive_outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:         gain_p_q        = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:         gain_i_q        = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:         gain_d_q        = cfg_wdata[GAIN_W-1:0];
          REG_INTEGRAL_LIMIT: integ_limit_q   = cfg_wdata[ILIM_W-1:0];
          REG_OUTPUT_LIMIT:   drive_limit_q   = cfg_wdata[OLIM_W-1:0];
          REG_SEP_ENABLE:     sep_enable_q    = cfg_wdata[0];
          REG_SEP_THRESHOLD:  sep_threshold_q = cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_expect_q.push_back(pid_drive_predict(in_setpoint, in_measured));
      if (out_valid && out_ready) begin
        if (drive_expect_q.size() == 0) begin
          if (fail_total < PRINT_CAP)
            $display("%0t: result with no request outstanding, actual drive %0d flag %0b",
                     $time, out_drive, out_drive_clamped);
          fail_total++;
        end else begin
          exp_r = drive_expect_q.pop_front();
          if (out_drive !== exp_r.drive) begin
            if (fail_total < PRINT_CAP)
              $display("%0t: drive mismatch, expected %0d, actual %0d",
                       $time, exp_r.drive, out_drive);
            fail_total++;
          end
          if (out_drive_clamped !== exp_r.clamped) begin
            if (fail_total < PRINT_CAP)
              $display("%0t: clamp flag mismatch, expected %0b, actual %0b",
                       $time, exp_r.clamped, out_drive_clamped);
            fail_total++;
          end
        end
      end
      drive_outstanding <= drive_expect_q.size();
    end
    mismatch_count <= fail_total;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the positional PID unit: a directed run over sample extremes,
// clamp boundaries, zero limits and separation thresholds, then random
// requests under a series of random register settings, with random idling on
// both channels. The checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import ppis_pkg::*;

  localparam int                   RANDOM_ITEMS   = 1850;
  localparam int                   CALM_TAIL      = 300;
  localparam int                   WATCHDOG_LIMIT = 2000;
  localparam int                   SETTLE_CYCLES  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 3'd7;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]               cfg_index = '0;
  logic [CFG_DATA_W-1:0]              cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [SAMPLE_WIDTH_DEF-1:0] in_setpoint = '0;
  logic signed [SAMPLE_WIDTH_DEF-1:0] in_measured = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [DRIVE_W-1:0]          out_drive;
  logic                               out_drive_clamped;

  int   drive_outstanding;
  int   mismatch_count;
  logic idle_on = 1'b1;
  int   out_hold = 0;
  int   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_pid_integral_separation_unit uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_setpoint, .in_measured,
    .out_valid, .out_ready, .out_drive, .out_drive_clamped
  );

  ppis_drive_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_setpoint, .in_measured,
    .out_valid, .out_ready, .out_drive, .out_drive_clamped,
    .drive_outstanding, .mismatch_count
  );

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (out_hold > 0) out_hold = out_hold - 1;
    else if (idle_on && $urandom_range(0, 5) == 0) out_hold = $urandom_range(1, 7);
    out_ready <= (out_hold == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic signed [SAMPLE_WIDTH_DEF-1:0] sp,
                          input logic signed [SAMPLE_WIDTH_DEF-1:0] ms);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_setpoint <= sp;
    in_measured <= ms;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every request has returned.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Unused upper bits carry noise; the spare index must be ignored.
  task automatic apply_cfg(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd, input logic [ILIM_W-1:0] ilim,
                           input logic [OLIM_W-1:0] olim, input logic sep,
                           input logic [THR_W-1:0] thr);
    cfg_write(REG_GAIN_P, {8'($urandom), kp});
    cfg_write(REG_GAIN_I, {8'($urandom), ki});
    cfg_write(REG_GAIN_D, {8'($urandom), kd});
    cfg_write(REG_INTEGRAL_LIMIT, ilim);
    cfg_write(REG_OUTPUT_LIMIT, {9'($urandom), olim});
    cfg_write(REG_SEP_ENABLE, {23'($urandom), sep});
    cfg_write(REG_SEP_THRESHOLD, {8'($urandom), thr});
    cfg_write(REG_SPARE, 24'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  task automatic apply_random_cfg();
    logic [ILIM_W-1:0] ilim;
    logic [OLIM_W-1:0] olim;
    logic [THR_W-1:0]  thr;
    case ($urandom_range(0, 7))
      0: ilim = '0;
      1: ilim = '1;
      2, 3: ilim = 24'($urandom);
      default: ilim = 24'($urandom_range(0, 5000));
    endcase
    case ($urandom_range(0, 5))
      0: olim = '0;
      1: olim = '1;
      default: olim = 15'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: thr = '0;
      1: thr = '1;
      2: thr = 16'($urandom);
      default: thr = 16'($urandom_range(0, 2000));
    endcase
    apply_cfg(pick_gain(), pick_gain(), pick_gain(), ilim, olim, 1'($urandom), thr);
  endtask

  task automatic send_random();
    int sp, ms;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        sp = $urandom_range(0, 65535) - 32768;
        ms = $urandom_range(0, 65535) - 32768;
      end
      8, 9: begin
        sp = $urandom_range(0, 1) ? 32767 : -32768;
        ms = $urandom_range(0, 1) ? 32767 : -32768;
      end
      default: begin
        // small error so separation and integral limits come into play
        sp = $urandom_range(0, 65535) - 32768;
        ms = sp - ($urandom_range(0, 400) - 200);
        if (ms > 32767) ms = 32767;
        if (ms < -32768) ms = -32768;
      end
    endcase
    send_req(16'(sp), 16'(ms));
  endtask

  initial begin
    int sent;
    int phase_len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all gains and limits zero
    send_req(16'sh7fff, -16'sh8000);
    send_req(-16'sh8000, 16'sh7fff);
    send_req(16'sd0, 16'sd0);
    drain();

    // unit proportional gain: clamp exactly at the output limit boundary
    apply_cfg(16'd256, '0, '0, '1, '1, 1'b0, '0);
    send_req(16'sh7fff, 16'sd0);
    send_req(16'sh7fff, -16'sd1);
    send_req(-16'sh8000, 16'sd0);
    send_req(-16'sd32767, 16'sd0);
    send_req(16'sh7fff, -16'sh8000);
    send_req(-16'sh8000, 16'sh7fff);
    drain();

    // zero limits with extreme gains
    apply_cfg(16'h8000, 16'h7fff, 16'h7fff, '0, '0, 1'b0, '0);
    send_req(-16'sh8000, 16'sh7fff);
    send_req(16'sd0, 16'sd0);
    send_req(16'sd7, 16'sd7);
    drain();

    // separation with a zero threshold clears the integral every step
    apply_cfg('0, 16'd256, '0, 24'd1000, '1, 1'b1, '0);
    send_req(16'sd1, 16'sd0);
    send_req(16'sd0, 16'sd0);
    send_req(-16'sd1, 16'sd0);
    drain();

    // threshold just above and at the error, integral running into its limit
    apply_cfg('0, 16'd256, '0, 24'd300, '1, 1'b1, 16'd100);
    repeat (4) send_req(16'sd99, 16'sd0);
    send_req(16'sd100, 16'sd0);
    send_req(-16'sd99, 16'sd0);
    send_req(16'sd0, 16'sd100);
    drain();

    // largest threshold, most negative derivative gain
    apply_cfg('0, 16'h7fff, 16'h8000, '1, '1, 1'b1, '1);
    send_req(16'sh7fff, -16'sh8000);
    send_req(-16'sh8000, 16'sh7fff);
    send_req(16'sd0, 16'sd0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      apply_random_cfg();
      if (RANDOM_ITEMS - sent <= CALM_TAIL) idle_on <= 1'b0;
      else idle_on <= ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(60, 200);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        send_random();
        sent++;
      end
    end
    drain();

    if (mismatch_count == 0 && drive_outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== positional_pid_integral_separation_unit.f =====
rtl/core/ppis_pkg.sv
rtl/core/ppis_cfg_regs.sv
rtl/core/ppis_integrator.sv
rtl/core/positional_pid_integral_separation_unit.sv
verif/ppis_drive_checker.sv
verif/tb.sv
